>>> design/g4n_pkg.sv
// ----------------------------------------------------------------------------
// g4n_pkg: shared types and constants for the 4-D grid neighbour generator
// Field widths, register codes, queue sizing and the per-axis weight tables.
// ----------------------------------------------------------------------------
package g4n_pkg;

  // Grid shape
  localparam int AXES     = 4;
  localparam int SIDE_DEF = 4;
  localparam int IDX_W    = 8;
  localparam int AXIS_W   = 2;
  localparam int NB_MAX   = 2 * AXES;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_USED  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP_EDGES = 1'b1;
  localparam logic [2:0] DIMS_RESET = 3'd4;
  localparam logic [2:0] DIMS_MAX   = 3'd4;

  // Front-to-back queue; depth must be a power of two
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // Configuration as seen by the front end
  typedef struct packed {
    logic [2:0] dims;
    logic       wrap;
  } g4n_cfg_t;

  // One classified cell: base index, neighbours to send, edge flags per axis
  typedef struct packed {
    logic [IDX_W-1:0]  base;
    logic [NB_MAX-1:0] mask;
    logic [AXES-1:0]   top;
    logic [AXES-1:0]   bot;
  } g4n_entry_t;

  // Integer power, elaboration use only
  function automatic int g4n_pow(input int b, input int n);
    int r;
    r = 1;
    for (int i = 0; i < n; i++) r = r * b;
    return r;
  endfunction

  // Step along each axis, modulo the index width
  function automatic logic [AXES-1:0][IDX_W-1:0] g4n_weights(input int side);
    logic [AXES-1:0][IDX_W-1:0] w;
    for (int a = 0; a < AXES; a++) w[a] = IDX_W'(g4n_pow(side, a));
    return w;
  endfunction

  // Jump across the whole axis for wrapping, modulo the index width
  function automatic logic [AXES-1:0][IDX_W-1:0] g4n_wrap_weights(input int side);
    logic [AXES-1:0][IDX_W-1:0] w;
    for (int a = 0; a < AXES; a++) w[a] = IDX_W'((side - 1) * g4n_pow(side, a));
    return w;
  endfunction

endpackage

>>> design/g4n_if.sv
// ----------------------------------------------------------------------------
// g4n_if: valid/ready channels of the 4-D grid neighbour generator
// Cell items in, neighbour items out.
// ----------------------------------------------------------------------------
interface g4n_in_if import g4n_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, cell_index, input ready);
  modport sink   (input valid, cell_index, output ready);
endinterface

interface g4n_out_if import g4n_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  neighbor_index;
  logic [AXIS_W-1:0] neighbor_axis;
  logic              toward_minus;
  logic              is_last;

  modport source (output valid, neighbor_index, neighbor_axis, toward_minus, is_last,
                  input ready);
  modport sink   (input valid, neighbor_index, neighbor_axis, toward_minus, is_last,
                  output ready);
endinterface

>>> design/grid4d_neighbor_index_gen_core.sv
// ----------------------------------------------------------------------------
// grid4d_neighbor_index_gen_core: 4-D grid neighbour index generator
// Flow: the classifier takes a cell, extracts its digits (one reciprocal
// multiply each) and queues the result; it can take the next cell once the
// result is queued. The emitter sends one neighbour item per cycle while
// the output is not stalled.
// Reset: synchronous rst_n empties the queue and output; dims_used=4, wrap=0.
// ----------------------------------------------------------------------------
module grid4d_neighbor_index_gen_core import g4n_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  g4n_in_if.sink                in_s,
  g4n_out_if.source             out_s,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0] dims_r;
  logic       wrap_r;
  g4n_cfg_t   cfg;

  logic       push_valid, push_ready, head_valid, pop;
  g4n_entry_t push_entry, head;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r <= DIMS_RESET;
      wrap_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIMS_USED:  dims_r <= cfg_data;
        CFG_WRAP_EDGES: wrap_r <= cfg_data[0];
        default:        ;
      endcase
    end
  end

  assign cfg.dims = dims_r;
  assign cfg.wrap = wrap_r;

  g4n_front #(.SIDE(SIDE)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_s       (in_s),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready)
  );

  g4n_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  g4n_back #(.SIDE(SIDE)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_s      (out_s)
  );

  // Hold a stalled classified cell until the queue takes it
  a_push_hold: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid && !push_ready |=> push_valid && $stable(push_entry))
    else $error("classified cell changed while queue full");

  // Cells without neighbours never reach the queue
  a_no_empty_mask: assert property (@(posedge clk) disable iff (!rst_n)
    head_valid |-> head.mask != '0)
    else $error("queued cell has empty neighbour mask");

  // Pop only a present cell
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue popped while empty");

endmodule

>>> design/g4n_front.sv
// ----------------------------------------------------------------------------
// g4n_front: cell classifier
// Splits a cell index into base-SIDE digits one per cycle, flags edge cells
// and builds the mask of neighbours to send, then queues the result.
// ----------------------------------------------------------------------------
module g4n_front import g4n_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  g4n_in_if.sink     in_s,
  input  g4n_cfg_t   cfg,
  output logic       push_valid,
  output g4n_entry_t push_entry,
  input  logic       push_ready
);

  // Reciprocal for digit extraction; exact for every 8-bit dividend
  localparam int RECIP_SH = 16;
  localparam int RECIP    = ((1 << RECIP_SH) + SIDE - 1) / SIDE;
  localparam int PROD_W   = IDX_W + RECIP_SH + 1;
  localparam logic [IDX_W-1:0] P4_MOD   = IDX_W'(g4n_pow(SIDE, AXES) % (1 << IDX_W));
  localparam logic [IDX_W-1:0] SIDE_M1  = IDX_W'(SIDE - 1);
  localparam logic [2:0]       STEP_PUSH = 3'(AXES);

  logic             busy_r, busy_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [IDX_W-1:0] rest_r, cell_r;
  logic [AXES-1:0]  top_r, bot_r;

  logic [PROD_W-1:0] prod;
  logic [IDX_W-1:0]  quot, rem;
  logic [2:0]        dims_eff;
  logic [NB_MAX-1:0] mask;
  logic              at_push, done, accept;

  // Divide the remaining index by SIDE
  always_comb begin
    prod = PROD_W'(rest_r) * PROD_W'(RECIP);
    quot = prod[RECIP_SH +: IDX_W];
    rem  = rest_r - IDX_W'((2 * IDX_W)'(quot) * (2 * IDX_W)'(SIDE));
  end

  // Classify: which neighbours exist for the active axes
  always_comb begin
    dims_eff = (cfg.dims > DIMS_MAX) ? DIMS_MAX : cfg.dims;
    for (int a = 0; a < AXES; a++) begin
      mask[2*a]   = (3'(a) < dims_eff) && (cfg.wrap || !top_r[a]);
      mask[2*a+1] = (3'(a) < dims_eff) && (cfg.wrap || !bot_r[a]);
    end
  end

  // Push when classified; a cell with no neighbours is dropped here
  always_comb begin
    at_push         = busy_r && (step_r == STEP_PUSH);
    push_valid      = at_push && (mask != '0);
    push_entry.base = cell_r - IDX_W'((2 * IDX_W)'(rest_r) * (2 * IDX_W)'(P4_MOD));
    push_entry.mask = mask;
    push_entry.top  = top_r;
    push_entry.bot  = bot_r;
    done            = at_push && ((mask == '0) || push_ready);
    in_s.ready      = !busy_r || done;
    accept          = in_s.valid && in_s.ready;
  end

  // Advance the digit counter
  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (done) begin
      busy_nxt = 1'b0;
    end else if (busy_r && !at_push) begin
      step_nxt = step_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

  // Digit datapath
  always_ff @(posedge clk) begin
    if (accept) begin
      rest_r <= in_s.cell_index;
      cell_r <= in_s.cell_index;
    end else if (busy_r && !at_push) begin
      rest_r                       <= quot;
      top_r[step_r[AXIS_W-1:0]]    <= (rem == SIDE_M1);
      bot_r[step_r[AXIS_W-1:0]]    <= (rem == '0);
    end
  end

endmodule

>>> design/g4n_queue.sv
// ----------------------------------------------------------------------------
// g4n_queue: classified-cell queue
// Small register FIFO that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
module g4n_queue import g4n_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  input  g4n_entry_t push_entry,
  output logic       push_ready,
  output logic       head_valid,
  output g4n_entry_t head,
  input  logic       pop
);

  g4n_entry_t     entries_r [QDEPTH];
  logic [QAW-1:0] wptr_r, rptr_r;
  logic [QCW-1:0] count_r, count_nxt;
  logic           push;

  always_comb begin
    push_ready = (count_r != QCW'(QDEPTH));
    head_valid = (count_r != '0);
    head       = entries_r[rptr_r];
    push       = push_valid && push_ready;
    count_nxt  = count_r + QCW'(push) - QCW'(pop);
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries_r[wptr_r] <= push_entry;
  end

endmodule

>>> design/g4n_back.sv
// ----------------------------------------------------------------------------
// g4n_back: neighbour emitter
// Walks the neighbour mask of the head cell, one neighbour item per cycle
// while the output is not stalled, into an output register.
// ----------------------------------------------------------------------------
module g4n_back import g4n_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  g4n_entry_t head,
  output logic       pop,
  g4n_out_if.source  out_s
);

  localparam logic [AXES-1:0][IDX_W-1:0] WGT  = g4n_weights(SIDE);
  localparam logic [AXES-1:0][IDX_W-1:0] WGTW = g4n_wrap_weights(SIDE);

  logic              out_valid_r;
  logic [IDX_W-1:0]  nb_idx_r;
  logic [AXIS_W-1:0] nb_axis_r;
  logic              minus_r, last_r;
  logic [NB_MAX-1:0] sent_r;

  logic [NB_MAX-1:0] remain, pick;
  logic [2:0]        sel;
  logic [AXIS_W-1:0] axis;
  logic              minus, last, load;
  logic [IDX_W-1:0]  nb_idx;

  // Pick the lowest neighbour still to send
  always_comb begin
    remain = head.mask & ~sent_r;
    sel    = '0;
    for (int i = NB_MAX - 1; i >= 0; i--) begin
      if (remain[i]) sel = 3'(i);
    end
    pick  = NB_MAX'(1) << sel;
    axis  = sel[2:1];
    minus = sel[0];
    last  = ((remain & ~pick) == '0);
  end

  // Step from the centre, or jump across the axis at a wrapped edge
  always_comb begin
    if (!minus) begin
      nb_idx = head.top[axis] ? head.base - WGTW[axis] : head.base + WGT[axis];
    end else begin
      nb_idx = head.bot[axis] ? head.base + WGTW[axis] : head.base - WGT[axis];
    end
  end

  assign load = head_valid && (!out_valid_r || out_s.ready);
  assign pop  = load && last;

  // Output register and progress through the mask
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sent_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        sent_r      <= last ? '0 : (sent_r | pick);
      end else if (out_s.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      nb_idx_r  <= nb_idx;
      nb_axis_r <= axis;
      minus_r   <= minus;
      last_r    <= last;
    end
  end

  assign out_s.valid          = out_valid_r;
  assign out_s.neighbor_index = nb_idx_r;
  assign out_s.neighbor_axis  = nb_axis_r;
  assign out_s.toward_minus   = minus_r;
  assign out_s.is_last        = last_r;

endmodule

>>> tb/sv/g4n_nbr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// g4n_nbr_checker: neighbour prediction and comparison for the grid generator
// Watches the cell and neighbour channels and the register port, works out the
// neighbours of every accepted cell and checks each neighbour item in order.
// ----------------------------------------------------------------------------
module g4n_nbr_checker import g4n_pkg::*; #(
  parameter int SIDE = SIDE_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  g4n_in_if                     cell_ch,
  g4n_out_if                    nbr_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  end_of_test,
  output int                    fail_count,
  output int                    pending,
  output int                    results_seen
);

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [AXIS_W-1:0] axis;
    logic              minus;
    logic              last;
  } nbr_t;

  // Shadow copy of the registers
  logic [2:0] dims_shadow;
  logic       wrap_shadow;

  nbr_t nbr_expected[$];
  nbr_t got;
  nbr_t want;
  bit   end_seen;

  initial begin
    fail_count   = 0;
    pending      = 0;
    results_seen = 0;
    end_seen     = 1'b0;
    dims_shadow  = DIMS_RESET;
    wrap_shadow  = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fail_count++;
  endtask

  function automatic nbr_t make_nbr(input int idx, input int axis, input bit minus);
    nbr_t n;
    n.idx   = IDX_W'(idx);
    n.axis  = AXIS_W'(axis);
    n.minus = minus;
    n.last  = 1'b0;
    return n;
  endfunction

  // Split the cell into digits, then list the neighbours axis by axis
  task automatic predict_neighbours(input logic [IDX_W-1:0] cell_idx);
    int   coord[AXES];
    int   weight[AXES];
    int   rest;
    int   w;
    int   base;
    int   dims;
    int   c;
    int   others;
    int   n;
    nbr_t found[NB_MAX];
    rest = cell_idx;
    w    = 1;
    base = 0;
    for (int a = 0; a < AXES; a++) begin
      coord[a]  = rest % SIDE;
      rest      = rest / SIDE;
      weight[a] = w;
      base      = base + coord[a] * w;
      w         = w * SIDE;
    end
    // dims_used above the axis count saturates
    dims = (dims_shadow > AXES) ? AXES : int'(dims_shadow);
    n    = 0;
    for (int a = 0; a < dims; a++) begin
      c      = coord[a];
      others = base - c * weight[a];
      if (wrap_shadow) begin
        found[n] = make_nbr(others + ((c + 1) % SIDE) * weight[a], a, 1'b0);
        n++;
        found[n] = make_nbr(others + ((c + SIDE - 1) % SIDE) * weight[a], a, 1'b1);
        n++;
      end else begin
        if (c + 1 < SIDE) begin
          found[n] = make_nbr(others + (c + 1) * weight[a], a, 1'b0);
          n++;
        end
        if (c >= 1) begin
          found[n] = make_nbr(others + (c - 1) * weight[a], a, 1'b1);
          n++;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      found[k].last = (k == n - 1);
      nbr_expected.push_back(found[k]);
    end
  endtask

  // Compare first, then queue new predictions, then take register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      dims_shadow = DIMS_RESET;
      wrap_shadow = 1'b0;
      nbr_expected.delete();
    end else begin
      if (nbr_ch.valid && nbr_ch.ready) begin
        got.idx   = nbr_ch.neighbor_index;
        got.axis  = nbr_ch.neighbor_axis;
        got.minus = nbr_ch.toward_minus;
        got.last  = nbr_ch.is_last;
        results_seen++;
        if (nbr_expected.size() == 0) begin
          report_mismatch($sformatf("neighbour item %0d with nothing expected", got.idx));
        end else begin
          want = nbr_expected.pop_front();
          if (got.idx !== want.idx)
            report_mismatch($sformatf("neighbor_index %0d, expected %0d", got.idx, want.idx));
          if (got.axis !== want.axis)
            report_mismatch($sformatf("neighbor_axis %0d, expected %0d (index %0d)",
                                      got.axis, want.axis, want.idx));
          if (got.minus !== want.minus)
            report_mismatch($sformatf("toward_minus %0b, expected %0b (index %0d)",
                                      got.minus, want.minus, want.idx));
          if (got.last !== want.last)
            report_mismatch($sformatf("is_last %0b, expected %0b (index %0d)",
                                      got.last, want.last, want.idx));
        end
      end
      if (cell_ch.valid && cell_ch.ready)
        predict_neighbours(cell_ch.cell_index);
      if (cfg_we) begin
        if (cfg_index == CFG_DIMS_USED)
          dims_shadow = cfg_data[2:0];
        else if (cfg_index == CFG_WRAP_EDGES)
          wrap_shadow = cfg_data[0];
      end
      if (end_of_test && !end_seen) begin
        end_seen = 1'b1;
        if (nbr_expected.size() != 0)
          report_mismatch($sformatf("%0d neighbour items never arrived", nbr_expected.size()));
      end
    end
    pending = nbr_expected.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the 4-D grid neighbour generator
// Drives cells through directed and random register settings with random
// gaps and back-pressure; the checker beside the block judges every item.
// ----------------------------------------------------------------------------
module tb_top;
  import g4n_pkg::*;

  localparam int RANDOM_CELLS    = 200;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 400000;

  // Corners, faces and centres under the reset settings
  localparam int DIRECTED_COUNT = 12;
  localparam logic [IDX_W-1:0] DIRECTED_CELLS [DIRECTED_COUNT] = '{
    8'd0, 8'd255, 8'd1, 8'd2, 8'd3, 8'd4, 8'd12, 8'd48, 8'd192, 8'd85, 8'd170, 8'd27
  };

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  end_of_test;

  int fail_count;
  int pending;
  int results_seen;
  int cycles;
  int cells_sent;
  int settings_used;

  bit calm;
  bit hold_off_req;

  g4n_in_if  cell_ch ();
  g4n_out_if nbr_ch ();

  grid4d_neighbor_index_gen_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (cell_ch),
    .out_s     (nbr_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  g4n_nbr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cell_ch      (cell_ch),
    .nbr_ch       (nbr_ch),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .end_of_test  (end_of_test),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Neighbour receiver: random stalls, calm stretches, one long hold-off
  initial begin
    int gap;
    int burst;
    nbr_ch.ready = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        @(negedge clk) nbr_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        nbr_ch.ready <= 1'b1;
      end else if (calm) begin
        @(negedge clk) nbr_ch.ready <= 1'b1;
      end else begin
        gap   = pick_gap();
        burst = $urandom_range(1, 12);
        if (gap > 0) begin
          @(negedge clk) nbr_ch.ready <= 1'b0;
          repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk) nbr_ch.ready <= 1'b1;
        repeat (burst - 1) @(negedge clk);
      end
    end
  end

  // Offer one cell, hold it until taken, then idle for a while
  task automatic send_cell(input logic [IDX_W-1:0] cell_idx);
    int gap;
    @(negedge clk);
    cell_ch.valid      <= 1'b1;
    cell_ch.cell_index <= cell_idx;
    do @(posedge clk); while (!cell_ch.ready);
    cells_sent++;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk) cell_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid, drain every expected neighbour and let the pipeline empty
  task automatic wait_idle();
    @(negedge clk) cell_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write both registers while idle; the wrap field carries random upper bits
  task automatic set_config(input logic [2:0] dims, input logic [CFG_DATA_W-1:0] wrap_word);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIMS_USED;
    cfg_data  <= dims;
    @(negedge clk);
    cfg_index <= CFG_WRAP_EDGES;
    cfg_data  <= wrap_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Random cell, biased now and then towards the grid faces
  function automatic logic [IDX_W-1:0] pick_cell();
    logic [IDX_W-1:0] c;
    c = IDX_W'($urandom_range(0, 255));
    if ($urandom_range(0, 9) < 3) begin
      for (int a = 0; a < AXES; a++)
        if ($urandom_range(0, 1)) c[2*a +: 2] = $urandom_range(0, 1) ? 2'd3 : 2'd0;
    end
    return c;
  endfunction

  // Stimulus
  initial begin
    int   random_cells;
    int   n;
    logic [2:0] dims;
    rst_n              = 1'b0;
    cell_ch.valid      = 1'b0;
    cell_ch.cell_index = '0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_DIMS_USED;
    cfg_data           = '0;
    end_of_test        = 1'b0;
    calm               = 1'b0;
    hold_off_req       = 1'b0;
    cells_sent         = 0;
    settings_used      = 1;
    random_cells       = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: all four axes, edges skipped; corners, faces, centres
    for (int i = 0; i < DIRECTED_COUNT; i++)
      send_cell(DIRECTED_CELLS[i]);

    // Wrapping on a full torus
    set_config(3'd4, 3'b001);
    send_cell(8'd0);
    send_cell(8'd255);
    send_cell(8'd85);
    send_cell(8'd170);
    send_cell(8'd63);

    // Zero axes: cells produce nothing
    set_config(3'd0, 3'b110);
    send_cell(8'd5);
    send_cell(8'd200);

    // Axis count above four saturates
    set_config(3'd7, 3'b111);
    send_cell(8'd0);
    send_cell(8'd129);

    // Single axis, no wrap
    set_config(3'd1, 3'b000);
    send_cell(8'd0);
    send_cell(8'd3);

    // Random phases; the second one fills the block behind a long hold-off
    for (int phase = 0; random_cells < RANDOM_CELLS; phase++) begin
      if (phase == 1) begin
        set_config(3'd4, 3'b001);
        calm = 1'b0;
        hold_off_req = 1'b1;
        n = 30;
      end else begin
        dims = ($urandom_range(0, 9) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
        set_config(dims, 3'($urandom_range(0, 7)));
        calm = ($urandom_range(0, 4) == 0);
        n = $urandom_range(15, 35);
      end
      for (int k = 0; k < n; k++)
        send_cell(pick_cell());
      random_cells += n;
    end

    // Drain, let stragglers show, then close the books
    calm = 1'b0;
    wait_idle();
    @(negedge clk) end_of_test <= 1'b1;
    @(posedge clk);
    @(negedge clk);
    $display("Run covered %0d cells over %0d register settings, %0d neighbour items checked,",
             cells_sent, settings_used, results_seen);
    $display("with wrap on and off, zero to seven axes and a long output hold-off.");
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
